// ----- rtl/core/brb_pkg.sv -----
// Package for the byte ring buffer: field widths, default sizes, operation
// and status codes, controller states and the count record type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package brb_pkg;

  localparam int unsigned SLOTS_DEF   = 1024;
  localparam int unsigned MAX_RUN_DEF = 64;

  localparam int unsigned OPCODE_W    = 3;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned COUNT_W     = 7;
  localparam int unsigned FIELD_W     = 10;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned IN_DATA_W   = 16;
  localparam int unsigned OUT_DATA_W  = 48;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ENQUEUE = 3'd0,
    OP_DEQUEUE = 3'd1,
    OP_PEEK    = 3'd2,
    OP_SKIP    = 3'd3,
    OP_CLEAR   = 3'd4,
    OP_STATUS  = 3'd5
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_REJECT   = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_ADV  = 3'b100
  } state_e;

  typedef struct packed {
    logic [FIELD_W-1:0] read_span;
    logic [FIELD_W-1:0] write_span;
    logic [FIELD_W-1:0] free_count;
    logic [FIELD_W-1:0] used_count;
  } counts_t;

endpackage

`default_nettype wire

// ----- rtl/core/brb_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module brb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/core/brb_counts.sv -----
// Fill level and contiguous span calculation from a write and a read position.
// Depends on brb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module brb_counts #(
  parameter int unsigned SLOTS = brb_pkg::SLOTS_DEF,
  localparam int unsigned IW   = $clog2(SLOTS),
  localparam int unsigned CW   = IW + 1
) (
  input  wire logic [IW-1:0]   wr_idx_i,
  input  wire logic [IW-1:0]   rd_idx_i,
  output logic      [CW-1:0]   used_o,
  output brb_pkg::counts_t     counts_o
);
  import brb_pkg::*;

  localparam logic [CW-1:0] SlotsC = CW'(SLOTS);

  logic [CW-1:0] w_ext;
  logic [CW-1:0] r_ext;
  logic [CW-1:0] used;
  logic [CW-1:0] free;
  logic [CW-1:0] wspan;
  logic [CW-1:0] rspan;
  logic          no_wrap;

  logic [CW+FIELD_W-1:0] used_x;
  logic [CW+FIELD_W-1:0] free_x;
  logic [CW+FIELD_W-1:0] wspan_x;
  logic [CW+FIELD_W-1:0] rspan_x;

  assign w_ext   = {1'b0, wr_idx_i};
  assign r_ext   = {1'b0, rd_idx_i};
  assign no_wrap = (rd_idx_i <= wr_idx_i);

  always_comb begin
    if (no_wrap) begin
      used  = w_ext - r_ext;
      rspan = w_ext - r_ext;
      if (rd_idx_i == '0) begin
        wspan = SlotsC - 1'b1 - w_ext;
      end else begin
        wspan = SlotsC - w_ext;
      end
    end else begin
      used  = SlotsC + w_ext - r_ext;
      rspan = SlotsC - r_ext;
      wspan = r_ext - 1'b1 - w_ext;
    end
    free = SlotsC - 1'b1 - used;
  end

  assign used_x  = {{FIELD_W{1'b0}}, used};
  assign free_x  = {{FIELD_W{1'b0}}, free};
  assign wspan_x = {{FIELD_W{1'b0}}, wspan};
  assign rspan_x = {{FIELD_W{1'b0}}, rspan};

  assign used_o              = used;
  assign counts_o.used_count = used_x[FIELD_W-1:0];
  assign counts_o.free_count = free_x[FIELD_W-1:0];
  assign counts_o.write_span = wspan_x[FIELD_W-1:0];
  assign counts_o.read_span  = rspan_x[FIELD_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/core/brb_ctrl.sv -----
// Controller of the byte ring buffer: positions, run sequencer, skip wrap
// loop and the output register. Drives the byte store through its RAM ports.
// Depends on brb_pkg and brb_counts.
`timescale 1ns / 1ps
`default_nettype none

module brb_ctrl #(
  parameter int unsigned SLOTS   = brb_pkg::SLOTS_DEF,
  parameter int unsigned MAX_RUN = brb_pkg::MAX_RUN_DEF,
  localparam int unsigned IW     = $clog2(SLOTS)
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [brb_pkg::OPCODE_W-1:0]   in_op_i,
  input  wire logic [brb_pkg::BYTE_W-1:0]     in_byte_i,
  input  wire logic [brb_pkg::COUNT_W-1:0]    in_count_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic      [brb_pkg::BYTE_W-1:0]     out_byte_o,
  output logic                                out_last_o,
  output logic      [brb_pkg::STATUS_W-1:0]   out_status_o,
  output brb_pkg::counts_t                    out_counts_o,
  output logic                                ram_we_o,
  output logic      [IW-1:0]                  ram_waddr_o,
  output logic      [brb_pkg::BYTE_W-1:0]     ram_wdata_o,
  output logic                                ram_re_o,
  output logic      [IW-1:0]                  ram_raddr_o,
  input  wire logic [brb_pkg::BYTE_W-1:0]     ram_rdata_i
);
  import brb_pkg::*;

  localparam int unsigned CW = IW + 1;
  localparam int unsigned AW = ((IW > COUNT_W) ? IW : COUNT_W) + 1;

  localparam logic [AW-1:0]      SlotsA  = AW'(SLOTS);
  localparam logic [IW-1:0]      LastIdx = IW'(SLOTS - 1);
  localparam logic [CW-1:0]      FullC   = CW'(SLOTS - 1);
  localparam logic [COUNT_W-1:0] MaxRunC = COUNT_W'(MAX_RUN);

  function automatic logic [IW-1:0] inc_idx(input logic [IW-1:0] idx);
    return (idx == LastIdx) ? '0 : idx + 1'b1;
  endfunction

  state_e             state_q, state_d;
  logic [IW-1:0]      wr_q, wr_d;
  logic [IW-1:0]      rd_q, rd_d;
  logic [IW-1:0]      fetch_q, fetch_d;
  logic [COUNT_W-1:0] remain_q, remain_d;
  logic               pend_q, pend_d;
  logic [AW-1:0]      acc_q, acc_d;

  logic               ovalid_q;
  logic [BYTE_W-1:0]  obyte_q;
  logic               olast_q;
  status_e            ostat_q;
  counts_t            ocnt_q;

  logic               load;
  logic [BYTE_W-1:0]  ld_byte;
  logic               ld_last;
  status_e            ld_stat;

  logic               out_free;
  logic               accept;
  logic               consume;
  logic               issue;
  op_e                op;
  logic [CW-1:0]      used_cur;
  logic [CW-1:0]      used_nxt_unused;
  counts_t            cnt_cur_unused;
  counts_t            cnt_nxt;
  logic [AW-1:0]      sum_raw;
  logic [AW-1:0]      sum_red;
  logic               run_bad;
  logic               full;

  brb_counts #(.SLOTS(SLOTS)) u_counts_cur (
    .wr_idx_i (wr_q),
    .rd_idx_i (rd_q),
    .used_o   (used_cur),
    .counts_o (cnt_cur_unused)
  );

  brb_counts #(.SLOTS(SLOTS)) u_counts_nxt (
    .wr_idx_i (wr_d),
    .rd_idx_i (rd_d),
    .used_o   (used_nxt_unused),
    .counts_o (cnt_nxt)
  );

  assign out_free   = !ovalid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign op         = op_e'(in_op_i);

  assign sum_raw = AW'(rd_q) + AW'(in_count_i);
  assign sum_red = (sum_raw >= SlotsA) ? sum_raw - SlotsA : sum_raw;
  assign full    = (used_cur == FullC);
  assign run_bad = (in_count_i == '0) || (in_count_i > MaxRunC)
                || (AW'(in_count_i) > AW'(used_cur));

  assign consume = (state_q == S_RUN) && pend_q && out_free;
  assign issue   = (state_q == S_RUN) && (remain_q != '0) && (!pend_q || consume);

  assign ram_waddr_o = wr_q;
  assign ram_wdata_o = in_byte_i;

  always_comb begin
    state_d     = state_q;
    wr_d        = wr_q;
    rd_d        = rd_q;
    fetch_d     = fetch_q;
    remain_d    = remain_q;
    pend_d      = pend_q;
    acc_d       = acc_q;
    ram_we_o    = 1'b0;
    ram_re_o    = 1'b0;
    ram_raddr_o = fetch_q;
    load        = 1'b0;
    ld_byte     = '0;
    ld_last     = 1'b1;
    ld_stat     = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        ram_raddr_o = rd_q;
        if (accept) begin
          unique case (op)
            OP_ENQUEUE: begin
              load = 1'b1;
              if (full) begin
                ld_stat = ST_OVERFLOW;
              end else begin
                ram_we_o = 1'b1;
                wr_d     = inc_idx(wr_q);
              end
            end
            OP_DEQUEUE, OP_PEEK: begin
              if (run_bad) begin
                load    = 1'b1;
                ld_stat = ST_REJECT;
              end else begin
                ram_re_o = 1'b1;
                fetch_d  = inc_idx(rd_q);
                remain_d = in_count_i - 1'b1;
                pend_d   = 1'b1;
                state_d  = S_RUN;
                if (op == OP_DEQUEUE) begin
                  rd_d = sum_red[IW-1:0];
                end
              end
            end
            OP_SKIP: begin
              acc_d   = sum_raw;
              state_d = S_ADV;
            end
            OP_CLEAR: begin
              load = 1'b1;
              wr_d = '0;
              rd_d = '0;
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      S_RUN: begin
        if (issue) begin
          ram_re_o = 1'b1;
          fetch_d  = inc_idx(fetch_q);
          remain_d = remain_q - 1'b1;
          pend_d   = 1'b1;
        end else if (consume) begin
          pend_d = 1'b0;
        end
        if (consume) begin
          load    = 1'b1;
          ld_byte = ram_rdata_i;
          ld_last = (remain_q == '0);
          if (remain_q == '0) begin
            state_d = S_IDLE;
          end
        end
      end
      S_ADV: begin
        if (acc_q >= SlotsA) begin
          acc_d = acc_q - SlotsA;
        end else if (out_free) begin
          rd_d    = acc_q[IW-1:0];
          load    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      wr_q     <= '0;
      rd_q     <= '0;
      fetch_q  <= '0;
      remain_q <= '0;
      pend_q   <= 1'b0;
      acc_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      wr_q     <= wr_d;
      rd_q     <= rd_d;
      fetch_q  <= fetch_d;
      remain_q <= remain_d;
      pend_q   <= pend_d;
      acc_q    <= acc_d;
      if (load) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      obyte_q <= ld_byte;
      olast_q <= ld_last;
      ostat_q <= ld_stat;
      ocnt_q  <= cnt_nxt;
    end
  end

  assign out_valid_o  = ovalid_q;
  assign out_byte_o   = obyte_q;
  assign out_last_o   = olast_q;
  assign out_status_o = ostat_q;
  assign out_counts_o = ocnt_q;

endmodule

`default_nettype wire

// ----- rtl/core/byte_ring_buffer.sv -----
// Top level of the byte ring buffer: stream ports, controller and byte store.
// Depends on brb_pkg, brb_ram, brb_counts and brb_ctrl.
//
// Each transfer on the slave side is one command; tuser selects enqueue,
// dequeue run, peek run, skip, clear or status. Every command gives one or
// more transfers on the master side, the final one marked by tlast, each
// carrying a status code and the used, free and contiguous span counts as
// they stand after the whole command.
// Enqueue, clear, status and refused runs give their result in the cycle after
// the command transfer; with a receiver that keeps up one such command is
// taken every cycle.
// A dequeue or peek run of N bytes reads the store through its single read
// port; each byte passes its read register and then the result register;
// with a receiver that keeps up the bytes follow one per cycle, and then the
// next command is taken. A skip subtracts the store size once for each time
// the new read position passes the end of the store.
// Reset empties the buffer by zeroing both positions; the store itself is not
// cleared, so the block takes commands directly after reset.
// When the receiver stalls, the result register holds its transfer, the run
// sequencer pauses, and no further command is taken until it drains.
`timescale 1ns / 1ps
`default_nettype none

module byte_ring_buffer #(
  parameter int unsigned SLOTS   = brb_pkg::SLOTS_DEF,
  parameter int unsigned MAX_RUN = brb_pkg::MAX_RUN_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // [7:0] in_byte, [14:8] byte_count, [15] zero
  input  wire logic [brb_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // [2:0] opcode
  input  wire logic [brb_pkg::OPCODE_W-1:0]     s_axis_tuser_i,
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  // [7:0] out_byte, [17:8] used_count, [27:18] free_count,
  // [37:28] write_span, [47:38] read_span
  output logic      [brb_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  output logic                                  m_axis_tlast_o,
  // [1:0] status
  output logic      [brb_pkg::STATUS_W-1:0]     m_axis_tuser_o
);
  import brb_pkg::*;

  localparam int unsigned IW = $clog2(SLOTS);

  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [IW-1:0]     ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;
  logic [BYTE_W-1:0] out_byte;
  counts_t           out_counts;

  brb_ctrl #(
    .SLOTS   (SLOTS),
    .MAX_RUN (MAX_RUN)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_op_i      (s_axis_tuser_i),
    .in_byte_i    (s_axis_tdata_i[BYTE_W-1:0]),
    .in_count_i   (s_axis_tdata_i[BYTE_W+COUNT_W-1:BYTE_W]),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_byte_o   (out_byte),
    .out_last_o   (m_axis_tlast_o),
    .out_status_o (m_axis_tuser_o),
    .out_counts_o (out_counts),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata)
  );

  brb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (SLOTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tdata_o = {out_counts.read_span, out_counts.write_span,
                           out_counts.free_count, out_counts.used_count, out_byte};

endmodule

`default_nettype wire
